FILE: rtl/core/grid_border_obstacle_extract_top_macros.svh
// assertion macros used by the checker file of the grid border extractor
// no dependencies; every macro expands to one labelled concurrent assertion
`ifndef GRID_BORDER_OBSTACLE_EXTRACT_TOP_MACROS_SVH
`define GRID_BORDER_OBSTACLE_EXTRACT_TOP_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define GBOE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define GBOE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define GBOE_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gboe_pkg.sv
// shared types and constants of the grid border obstacle extractor
// no dependencies; used by gboe_judge, the top level and the checker
package gboe_pkg;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int GW_BITS      = 11;
  localparam int GH_BITS      = 13;
  localparam int THR_BITS     = 8;
  localparam int IN_VAL_BITS  = 8;
  localparam int COL_OUT_BITS = 10;
  localparam int ROW_BITS     = 12;
  localparam int MAX_HEIGHT   = 4096;

  localparam logic [GW_BITS-1:0]  GW_RESET  = 11'd1024;
  localparam logic [GH_BITS-1:0]  GH_RESET  = 13'd1024;
  localparam logic [THR_BITS-1:0] THR_RESET = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH,
    CFG_GRID_HEIGHT,
    CFG_OCC_THRESHOLD
  } cfg_idx_t;

  // per-cell control passed from the position counters to the window logic
  typedef struct packed {
    logic emit;       // delay line full, centre cell is judged
    logic edge_cell;  // centre lies on the outer edge of the grid
    logic two_hits;   // edge cell lies on two opposite edges, so it is reported twice
  } judge_ctl_t;

endpackage

FILE: rtl/core/gboe_judge.sv
// 3x3 window registers and the obstacle boundary decision for the centre cell
// depends on gboe_pkg
module gboe_judge #(
  parameter int VALUE_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  gboe_pkg::judge_ctl_t           ctl,
  input  logic [gboe_pkg::THR_BITS-1:0]  thr,
  input  logic [VALUE_BITS-1:0]          col_top,
  input  logic [VALUE_BITS-1:0]          col_mid,
  input  logic [VALUE_BITS-1:0]          col_bot,
  output logic [1:0]                     hit_cnt
);
  import gboe_pkg::*;

  localparam int CMPW = (VALUE_BITS > THR_BITS) ? VALUE_BITS : THR_BITS;

  logic [VALUE_BITS-1:0] win_r [3][3];
  logic [CMPW-1:0]       thr_x;
  logic [CMPW-1:0]       centre_x;
  logic                  nb_above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (adv) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= col_top;
      win_r[1][2] <= col_mid;
      win_r[2][2] <= col_bot;
    end
  end

  // decision on the window as it stands after this shift
  always_comb begin
    thr_x    = CMPW'(thr);
    centre_x = CMPW'(win_r[1][2]);
    nb_above = (CMPW'(win_r[0][1]) > thr_x) || (CMPW'(win_r[1][1]) > thr_x) ||
               (CMPW'(win_r[2][1]) > thr_x) || (CMPW'(win_r[0][2]) > thr_x) ||
               (CMPW'(win_r[2][2]) > thr_x) || (CMPW'(col_top) > thr_x) ||
               (CMPW'(col_mid) > thr_x) || (CMPW'(col_bot) > thr_x);
    hit_cnt = 2'd0;
    if (ctl.emit && (centre_x < thr_x)) begin
      if (ctl.edge_cell) begin
        hit_cnt = ctl.two_hits ? 2'd2 : 2'd1;
      end else if (nb_above) begin
        hit_cnt = 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/grid_border_obstacle_extract_top.sv
// Grid border obstacle extractor: one cell accepted per cycle, results in raster order.
// A cell is judged when the cell grid_width+1 places later has been accepted and leaves
// stage one; its result is written into the output register as that cell leaves.
// Throughput: one cell per cycle unless stalled; a doubled report also stalls the input.
// Reset clears the counters, window, pipeline and output and restores the register
// defaults; the line memory is not cleared and needs no clearing pass.
module grid_border_obstacle_extract_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int VALUE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gboe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gboe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gboe_pkg::IN_VAL_BITS-1:0]  in_cell_value,
  input  logic                              in_first_of_grid,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gboe_pkg::COL_OUT_BITS-1:0] out_cell_col,
  output logic [gboe_pkg::ROW_BITS-1:0]     out_cell_row,
  output logic                              out_last_of_run
);
  import gboe_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 2);
  localparam int HW = ROW_BITS + 1;
  localparam int VB = VALUE_BITS;

  // configuration
  logic [GW_BITS-1:0]  gw_cfg_r;
  logic [GH_BITS-1:0]  gh_cfg_r;
  logic [THR_BITS-1:0] thr_r;
  logic [WW-1:0]       gw;
  logic [HW-1:0]       gh;

  // input position and centre position
  logic [CW-1:0]       col_r, cen_col_r;
  logic [ROW_BITS-1:0] row_r, cen_row_r;
  logic [WW-1:0]       fill_r;

  // stage one
  logic                s1_valid_r;
  logic [VB-1:0]       s1_v_r;
  logic [CW-1:0]       s1_x_r;
  logic [CW-1:0]       s1_col_r;
  logic [ROW_BITS-1:0] s1_row_r;
  judge_ctl_t          s1_ctl_r;

  // line memory, one word per column holding the two previous rows
  logic [2*VB-1:0]     line_mem [MAX_WIDTH];
  logic [2*VB-1:0]     mem_q_r;
  logic                fwd_r;
  logic [2*VB-1:0]     fwd_word_r;
  logic [2*VB-1:0]     rd_word;
  logic [2*VB-1:0]     wr_word;

  // output register
  logic                out_valid_r;
  logic                out_second_r;
  logic                out_last_r;
  logic [CW-1:0]       out_col_r;
  logic [ROW_BITS-1:0] out_row_r;

  logic                acc, s1_adv;
  logic [1:0]          hit_cnt;
  logic [VB-1:0]       v_in;
  logic                rs;
  logic [WW-1:0]       col0, col1, colinc, col2;
  logic [HW-1:0]       row0, row1, row2;
  logic [WW-1:0]       cc0, cc1, ccinc, cc2;
  logic [HW-1:0]       cr0, cr1, cr2;
  logic [WW-1:0]       fill0, fill_nxt;
  logic                emit, row_edge;
  judge_ctl_t          ctl_nxt;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_cfg_r <= GW_RESET;
      gh_cfg_r <= GH_RESET;
      thr_r    <= THR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_WIDTH:    gw_cfg_r <= cfg_wdata[GW_BITS-1:0];
        CFG_GRID_HEIGHT:   gh_cfg_r <= cfg_wdata[GH_BITS-1:0];
        CFG_OCC_THRESHOLD: thr_r    <= cfg_wdata[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // saturated grid sizes
  always_comb begin
    if (gw_cfg_r == '0) begin
      gw = WW'(1);
    end else if (32'(gw_cfg_r) > 32'(MAX_WIDTH)) begin
      gw = WW'(MAX_WIDTH);
    end else begin
      gw = WW'(gw_cfg_r);
    end
    if (gh_cfg_r == '0) begin
      gh = HW'(1);
    end else if (32'(gh_cfg_r) > 32'(MAX_HEIGHT)) begin
      gh = HW'(MAX_HEIGHT);
    end else begin
      gh = HW'(gh_cfg_r);
    end
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || (out_ready && !out_second_r));
  assign in_ready = !s1_valid_r || s1_adv;
  assign acc      = in_valid && in_ready;
  assign v_in     = VB'(in_cell_value);

  // position bookkeeping for the accepted cell
  always_comb begin
    rs    = in_first_of_grid && ((col_r != '0) || (row_r != '0));
    col0  = rs ? '0 : WW'(col_r);
    row0  = rs ? '0 : HW'(row_r);
    cc0   = rs ? '0 : WW'(cen_col_r);
    cr0   = rs ? '0 : HW'(cen_row_r);
    fill0 = rs ? '0 : fill_r;

    col1 = col0;
    row1 = row0;
    if (col0 >= gw) begin
      col1 = '0;
      row1 = row0 + 1'b1;
    end
    if (row1 >= gh) begin
      row1 = '0;
    end
    colinc = col1 + 1'b1;
    col2   = colinc;
    row2   = row1;
    if (colinc >= gw) begin
      col2 = '0;
      row2 = row1 + 1'b1;
      if (row2 >= gh) begin
        row2 = '0;
      end
    end

    emit     = fill0 >= (gw + 1'b1);
    fill_nxt = emit ? fill0 : fill0 + 1'b1;

    cc1 = cc0;
    cr1 = cr0;
    if (cc0 >= gw) begin
      cc1 = '0;
      cr1 = cr0 + 1'b1;
    end
    if (cr1 >= gh) begin
      cr1 = '0;
    end
    ccinc = cc1 + 1'b1;
    cc2   = ccinc;
    cr2   = cr1;
    if (ccinc >= gw) begin
      cc2 = '0;
      cr2 = cr1 + 1'b1;
      if (cr2 >= gh) begin
        cr2 = '0;
      end
    end

    row_edge          = (cr1 == '0) || (cr1 == gh - 1'b1);
    ctl_nxt.emit      = emit;
    ctl_nxt.edge_cell = row_edge || (cc1 == '0) || (cc1 == gw - 1'b1);
    ctl_nxt.two_hits  = row_edge ? ((cr1 == '0) && (cr1 == gh - 1'b1))
                                 : ((cc1 == '0) && (cc1 == gw - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      cen_col_r <= '0;
      cen_row_r <= '0;
      fill_r    <= '0;
    end else if (acc) begin
      col_r  <= CW'(col2);
      row_r  <= ROW_BITS'(row2);
      fill_r <= fill_nxt;
      if (emit) begin
        cen_col_r <= CW'(cc2);
        cen_row_r <= ROW_BITS'(cr2);
      end else begin
        cen_col_r <= CW'(cc0);
        cen_row_r <= ROW_BITS'(cr0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_v_r   <= v_in;
      s1_x_r   <= CW'(col1);
      s1_col_r <= CW'(cc1);
      s1_row_r <= ROW_BITS'(cr1);
      s1_ctl_r <= ctl_nxt;
    end
  end

  // line memory; a read of the column written in the same cycle takes the new word
  assign rd_word = fwd_r ? fwd_word_r : mem_q_r;
  assign wr_word = {rd_word[VB-1:0], s1_v_r};

  always_ff @(posedge clk) begin
    if (acc) begin
      mem_q_r <= line_mem[CW'(col1)];
    end
    if (s1_adv) begin
      line_mem[s1_x_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (acc) begin
      fwd_r <= s1_adv && (CW'(col1) == s1_x_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_word_r <= wr_word;
    end
  end

  gboe_judge #(
    .VALUE_BITS(VALUE_BITS)
  ) u_judge (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .ctl     (s1_ctl_r),
    .thr     (thr_r),
    .col_top (rd_word[2*VB-1:VB]),
    .col_mid (rd_word[VB-1:0]),
    .col_bot (s1_v_r),
    .hit_cnt (hit_cnt)
  );

  // output register, a doubly counted cell is sent as two requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_second_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else if (s1_adv && (hit_cnt != 2'd0)) begin
      out_valid_r  <= 1'b1;
      out_second_r <= (hit_cnt == 2'd2);
      out_last_r   <= (hit_cnt == 2'd1);
    end else if (out_valid_r && out_ready) begin
      if (out_second_r) begin
        out_second_r <= 1'b0;
        out_last_r   <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (hit_cnt != 2'd0)) begin
      out_col_r <= s1_col_r;
      out_row_r <= s1_row_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_col    = COL_OUT_BITS'(out_col_r);
  assign out_cell_row    = out_row_r;
  assign out_last_of_run = out_last_r;

endmodule

FILE: rtl/core/gboe_chk.sv
// port-level checker for grid_border_obstacle_extract_top, bound to it below
// depends on gboe_pkg and grid_border_obstacle_extract_top_macros.svh
`include "grid_border_obstacle_extract_top_macros.svh"

module gboe_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gboe_pkg::COL_OUT_BITS-1:0] out_cell_col,
  input logic [gboe_pkg::ROW_BITS-1:0]     out_cell_row,
  input logic                              out_last_of_run
);
  import gboe_pkg::*;

  // nothing is offered in the cycle after reset
  `GBOE_ASSERT_NXT_ALL(a_reset_quiet, clk, !rst_n, !out_valid, "result valid after reset")

  // a stalled result keeps its payload
  `GBOE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_cell_col) && $stable(out_cell_row) && $stable(out_last_of_run), "stalled result changed")

  // the first of a doubled report is followed by the closing one on the same cell
  `GBOE_ASSERT_NXT(a_double_pair, clk, rst_n, out_valid && out_ready && !out_last_of_run, out_valid && out_last_of_run && $stable(out_cell_col) && $stable(out_cell_row), "second report of a cell missing")

  // with the output empty the input side never stalls
  `GBOE_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind grid_border_obstacle_extract_top gboe_chk u_gboe_chk (.*);
